>>> sv/emrmb_pkg.sv
// Shared types, register offsets and constants of the MAC/MDIO register block.
package emrmb_pkg;

   localparam int PHY_ADDRESS_DEFAULT = 1;

   typedef logic [1:0]  opcode_type;
   typedef logic [12:0] offset_type;
   typedef logic [1:0]  rx_outcome_type;
   typedef logic [1:0]  mdio_op_type;
   typedef logic [4:0]  phy_index_type;

   localparam opcode_type OP_READ     = 2'd0;
   localparam opcode_type OP_WRITE    = 2'd1;
   localparam opcode_type OP_RX_FRAME = 2'd2;
   localparam opcode_type OP_NONE     = 2'd3;

   localparam rx_outcome_type RX_STOPPED  = 2'd0;
   localparam rx_outcome_type RX_DROPPED  = 2'd1;
   localparam rx_outcome_type RX_ACCEPTED = 2'd2;

   localparam mdio_op_type MDIO_OP_WRITE = 2'd1;
   localparam mdio_op_type MDIO_OP_READ  = 2'd3;

   localparam phy_index_type PHY_REG_BMCR     = 5'd0;
   localparam phy_index_type PHY_REG_ID_FIRST = 5'd1;
   localparam phy_index_type PHY_REG_ID_LAST  = 5'd3;

   localparam offset_type OFF_MAC_CONFIG    = 13'h0000;
   localparam offset_type OFF_VERSION       = 13'h0020;
   localparam offset_type OFF_MAC_IRQ_EN    = 13'h00b4;
   localparam offset_type OFF_HW_FEATURE0   = 13'h011c;
   localparam offset_type OFF_HW_FEATURE1   = 13'h0120;
   localparam offset_type OFF_MDIO_ADDRESS  = 13'h0200;
   localparam offset_type OFF_MDIO_DATA     = 13'h0204;
   localparam offset_type OFF_MAC_ADDR_HIGH = 13'h0300;
   localparam offset_type OFF_MAC_ADDR_LOW  = 13'h0304;
   localparam offset_type OFF_BUS_MODE      = 13'h1000;
   localparam offset_type OFF_SYSBUS_MODE   = 13'h1004;
   localparam offset_type OFF_CH_CONTROL    = 13'h1100;
   localparam offset_type OFF_TX_CONTROL    = 13'h1104;
   localparam offset_type OFF_RX_CONTROL    = 13'h1108;
   localparam offset_type OFF_TX_BASE_HIGH  = 13'h1110;
   localparam offset_type OFF_TX_BASE_LOW   = 13'h1114;
   localparam offset_type OFF_RX_BASE_HIGH  = 13'h1118;
   localparam offset_type OFF_RX_BASE_LOW   = 13'h111c;
   localparam offset_type OFF_TX_TAIL       = 13'h1120;
   localparam offset_type OFF_TX_RING_LEN   = 13'h112c;
   localparam offset_type OFF_RX_RING_LEN   = 13'h1130;
   localparam offset_type OFF_CH_IRQ_EN     = 13'h1134;
   localparam offset_type OFF_TX_CUR_PTR    = 13'h1144;
   localparam offset_type OFF_RX_CUR_PTR    = 13'h114c;
   localparam offset_type OFF_CH_STATUS     = 13'h1160;

   localparam logic [31:0] VERSION_VALUE     = 32'h0000_3251;
   localparam logic [31:0] HW_FEATURE0_VALUE = 32'h0000_0023;
   localparam logic [31:0] HW_FEATURE1_VALUE = 32'h0000_0145;

   localparam logic [31:0] ST_TI  = 32'h0000_0001;
   localparam logic [31:0] ST_RI  = 32'h0000_0040;
   localparam logic [31:0] ST_NIS = 32'h0000_8000;

   localparam logic [15:0] PHY_BMCR_RESET_MASK = 16'h8200;
   localparam logic [15:0] MDIO_NO_PHY_DATA    = 16'hffff;
   localparam logic [31:0] RX_WB_FIRST_LAST    = 32'h3000_0000;
   localparam logic [31:0] RX_DESC_STRIDE      = 32'd16;

   typedef struct packed {
      opcode_type  opcode;
      offset_type  register_offset;
      logic [31:0] write_data;
      logic        rx_descriptor_owned;
      logic [13:0] rx_frame_size;
   } req_type;

   typedef struct packed {
      logic [31:0]    read_data;
      logic           irq_line;
      rx_outcome_type rx_outcome;
      logic [31:0]    rx_writeback_address;
      logic [31:0]    rx_writeback_word3;
   } rsp_type;

   // Clause-22 PHY register contents after reset
   function automatic logic [15:0] phy_reset_value(input logic [4:0] idx);
      logic [15:0] val;
      case (idx)
         5'd0:    val = 16'h1140;
         5'd1:    val = 16'h796d;
         5'd2:    val = 16'h0007;
         5'd3:    val = 16'hc0f0;
         5'd4:    val = 16'h01e1;
         5'd5:    val = 16'h45e1;
         default: val = 16'h0000;
      endcase
      return val;
   endfunction

endpackage

>>> sv/emrmb_if.sv
// Request and response channel interfaces of the MAC/MDIO register block.
interface emrmb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [12:0] register_offset;
   logic [31:0] write_data;
   logic        rx_descriptor_owned;
   logic [13:0] rx_frame_size;

   modport source (output valid, opcode, register_offset, write_data, rx_descriptor_owned,
                   rx_frame_size, input ready);
   modport sink (input valid, opcode, register_offset, write_data, rx_descriptor_owned,
                 rx_frame_size, output ready);
endinterface

interface emrmb_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic        irq_line;
   logic [1:0]  rx_outcome;
   logic [31:0] rx_writeback_address;
   logic [31:0] rx_writeback_word3;

   modport source (output valid, read_data, irq_line, rx_outcome, rx_writeback_address,
                   rx_writeback_word3, input ready);
   modport sink (input valid, read_data, irq_line, rx_outcome, rx_writeback_address,
                 rx_writeback_word3, output ready);
endinterface

>>> sv/emrmb_regs.sv
// MAC/DMA register file, PHY register store and per-request response logic.
module emrmb_regs
   import emrmb_pkg::*;
#(
   parameter int PHY_ADDRESS = PHY_ADDRESS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    update_en,
   input  req_type req,
   output rsp_type rsp
);

   logic [31:0] mac_config_ff, mac_config_in;
   logic [31:0] mac_irq_en_ff, mac_irq_en_in;
   logic [31:0] mdio_address_ff, mdio_address_in;
   logic [31:0] mdio_data_ff, mdio_data_in;
   logic [31:0] mac_addr_high_ff, mac_addr_high_in;
   logic [31:0] mac_addr_low_ff, mac_addr_low_in;
   logic [31:0] bus_mode_ff, bus_mode_in;
   logic [31:0] sysbus_mode_ff, sysbus_mode_in;
   logic [31:0] ch_control_ff, ch_control_in;
   logic [31:0] tx_control_ff, tx_control_in;
   logic [31:0] rx_control_ff, rx_control_in;
   logic [31:0] tx_base_high_ff, tx_base_high_in;
   logic [31:0] tx_base_low_ff, tx_base_low_in;
   logic [31:0] rx_base_high_ff, rx_base_high_in;
   logic [31:0] rx_base_low_ff, rx_base_low_in;
   logic [31:0] tx_ring_len_ff, tx_ring_len_in;
   logic [31:0] rx_ring_len_ff, rx_ring_len_in;
   logic [31:0] ch_irq_en_ff, ch_irq_en_in;
   logic [31:0] ch_status_ff, ch_status_in;
   logic [31:0] tx_cur_ptr_ff, tx_cur_ptr_in;
   logic [31:0] rx_cur_ptr_ff, rx_cur_ptr_in;

   logic [15:0] phy_ff [32];

   logic        phy_we;
   logic [4:0]  phy_waddr;
   logic [15:0] phy_wdata;
   logic [4:0]  mdio_phy;
   logic [4:0]  mdio_reg;
   mdio_op_type mdio_op;
   logic [15:0] phy_rdata;
   logic [31:0] read_mux;
   logic        rx_accept;
   logic [31:0] rx_ptr_inc;
   logic [31:0] rx_ring_end;

   assign mdio_phy  = req.write_data[25:21];
   assign mdio_reg  = req.write_data[20:16];
   assign mdio_op   = req.write_data[3:2];
   assign phy_rdata = phy_ff[mdio_reg];

   assign rx_accept   = (req.opcode == OP_RX_FRAME) && rx_control_ff[0] &&
                        req.rx_descriptor_owned;
   assign rx_ptr_inc  = rx_cur_ptr_ff + RX_DESC_STRIDE;
   assign rx_ring_end = rx_base_low_ff + {rx_ring_len_ff[27:0], 4'b0000};

   always_comb begin
      unique case (req.register_offset)
         OFF_VERSION:       read_mux = VERSION_VALUE;
         OFF_HW_FEATURE0:   read_mux = HW_FEATURE0_VALUE;
         OFF_HW_FEATURE1:   read_mux = HW_FEATURE1_VALUE;
         OFF_MAC_CONFIG:    read_mux = mac_config_ff;
         OFF_MAC_IRQ_EN:    read_mux = mac_irq_en_ff;
         OFF_MDIO_ADDRESS:  read_mux = mdio_address_ff;
         OFF_MDIO_DATA:     read_mux = mdio_data_ff;
         OFF_MAC_ADDR_HIGH: read_mux = mac_addr_high_ff;
         OFF_MAC_ADDR_LOW:  read_mux = mac_addr_low_ff;
         OFF_BUS_MODE:      read_mux = bus_mode_ff;
         OFF_SYSBUS_MODE:   read_mux = sysbus_mode_ff;
         OFF_CH_CONTROL:    read_mux = ch_control_ff;
         OFF_TX_CONTROL:    read_mux = tx_control_ff;
         OFF_RX_CONTROL:    read_mux = rx_control_ff;
         OFF_TX_BASE_HIGH:  read_mux = tx_base_high_ff;
         OFF_TX_BASE_LOW:   read_mux = tx_base_low_ff;
         OFF_RX_BASE_HIGH:  read_mux = rx_base_high_ff;
         OFF_RX_BASE_LOW:   read_mux = rx_base_low_ff;
         OFF_TX_RING_LEN:   read_mux = tx_ring_len_ff;
         OFF_RX_RING_LEN:   read_mux = rx_ring_len_ff;
         OFF_CH_IRQ_EN:     read_mux = ch_irq_en_ff;
         OFF_TX_CUR_PTR:    read_mux = tx_cur_ptr_ff;
         OFF_RX_CUR_PTR:    read_mux = rx_cur_ptr_ff;
         OFF_CH_STATUS:     read_mux = ch_status_ff;
         default:           read_mux = 32'h0;
      endcase
   end

   // Next state as if the request is taken; loaded only when update_en is high
   always_comb begin
      mac_config_in    = mac_config_ff;
      mac_irq_en_in    = mac_irq_en_ff;
      mdio_address_in  = mdio_address_ff;
      mdio_data_in     = mdio_data_ff;
      mac_addr_high_in = mac_addr_high_ff;
      mac_addr_low_in  = mac_addr_low_ff;
      bus_mode_in      = bus_mode_ff;
      sysbus_mode_in   = sysbus_mode_ff;
      ch_control_in    = ch_control_ff;
      tx_control_in    = tx_control_ff;
      rx_control_in    = rx_control_ff;
      tx_base_high_in  = tx_base_high_ff;
      tx_base_low_in   = tx_base_low_ff;
      rx_base_high_in  = rx_base_high_ff;
      rx_base_low_in   = rx_base_low_ff;
      tx_ring_len_in   = tx_ring_len_ff;
      rx_ring_len_in   = rx_ring_len_ff;
      ch_irq_en_in     = ch_irq_en_ff;
      ch_status_in     = ch_status_ff;
      tx_cur_ptr_in    = tx_cur_ptr_ff;
      rx_cur_ptr_in    = rx_cur_ptr_ff;
      phy_we           = 1'b0;
      phy_waddr        = mdio_reg;
      phy_wdata        = mdio_data_ff[15:0];

      if (req.opcode == OP_WRITE) begin
         unique case (req.register_offset)
            OFF_MAC_CONFIG:    mac_config_in    = req.write_data;
            OFF_MAC_IRQ_EN:    mac_irq_en_in    = req.write_data;
            OFF_MAC_ADDR_HIGH: mac_addr_high_in = req.write_data;
            OFF_MAC_ADDR_LOW:  mac_addr_low_in  = req.write_data;
            OFF_MDIO_DATA:     mdio_data_in     = req.write_data;
            OFF_MDIO_ADDRESS: begin
               if (req.write_data[0]) begin
                  if (mdio_phy == 5'(PHY_ADDRESS)) begin
                     if (mdio_op == MDIO_OP_READ) begin
                        mdio_data_in = {16'h0000, phy_rdata};
                     end else if (mdio_op == MDIO_OP_WRITE) begin
                        // ID registers are read-only; BMCR self-clearing bits never stick
                        phy_we = (mdio_reg == PHY_REG_BMCR) || (mdio_reg > PHY_REG_ID_LAST);
                        if (mdio_reg == PHY_REG_BMCR) begin
                           phy_wdata = mdio_data_ff[15:0] & ~PHY_BMCR_RESET_MASK;
                        end
                     end
                  end else begin
                     mdio_data_in = {16'h0000, MDIO_NO_PHY_DATA};
                  end
                  mdio_address_in = {req.write_data[31:1], 1'b0};
               end else begin
                  mdio_address_in = req.write_data;
               end
            end
            OFF_BUS_MODE:     bus_mode_in    = {req.write_data[31:1], 1'b0};
            OFF_SYSBUS_MODE:  sysbus_mode_in = req.write_data;
            OFF_CH_CONTROL:   ch_control_in  = req.write_data;
            OFF_TX_CONTROL:   tx_control_in  = req.write_data;
            OFF_RX_CONTROL:   rx_control_in  = req.write_data;
            OFF_TX_BASE_HIGH: tx_base_high_in = req.write_data;
            OFF_TX_BASE_LOW: begin
               tx_base_low_in = req.write_data;
               tx_cur_ptr_in  = req.write_data;
            end
            OFF_RX_BASE_HIGH: rx_base_high_in = req.write_data;
            OFF_RX_BASE_LOW: begin
               rx_base_low_in = req.write_data;
               rx_cur_ptr_in  = req.write_data;
            end
            OFF_TX_TAIL: begin
               if (tx_control_ff[0]) begin
                  ch_status_in = ch_status_ff | ST_TI | ST_NIS;
               end
            end
            OFF_TX_RING_LEN: tx_ring_len_in = req.write_data;
            OFF_RX_RING_LEN: rx_ring_len_in = req.write_data;
            OFF_CH_IRQ_EN:   ch_irq_en_in   = req.write_data;
            OFF_CH_STATUS:   ch_status_in   = ch_status_ff & ~req.write_data;
            default: ;
         endcase
      end

      if (rx_accept) begin
         rx_cur_ptr_in = (rx_ptr_inc > rx_ring_end) ? rx_base_low_ff : rx_ptr_inc;
         ch_status_in  = ch_status_ff | ST_RI | ST_NIS;
      end
   end

   always_comb begin
      rsp.read_data            = (req.opcode == OP_READ) ? read_mux : 32'h0;
      rsp.irq_line             = |(ch_status_in & ch_irq_en_in & (ST_TI | ST_RI));
      rsp.rx_outcome           = RX_STOPPED;
      rsp.rx_writeback_address = 32'h0;
      rsp.rx_writeback_word3   = 32'h0;
      if (req.opcode == OP_RX_FRAME && rx_control_ff[0]) begin
         rsp.rx_outcome = req.rx_descriptor_owned ? RX_ACCEPTED : RX_DROPPED;
      end
      if (rx_accept) begin
         rsp.rx_writeback_address = rx_cur_ptr_ff;
         rsp.rx_writeback_word3   = RX_WB_FIRST_LAST |
                                    {17'h0, 15'({1'b0, req.rx_frame_size} + 15'd4)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_config_ff    <= '0;
         mac_irq_en_ff    <= '0;
         mdio_address_ff  <= '0;
         mdio_data_ff     <= '0;
         mac_addr_high_ff <= '0;
         mac_addr_low_ff  <= '0;
         bus_mode_ff      <= '0;
         sysbus_mode_ff   <= '0;
         ch_control_ff    <= '0;
         tx_control_ff    <= '0;
         rx_control_ff    <= '0;
         tx_base_high_ff  <= '0;
         tx_base_low_ff   <= '0;
         rx_base_high_ff  <= '0;
         rx_base_low_ff   <= '0;
         tx_ring_len_ff   <= '0;
         rx_ring_len_ff   <= '0;
         ch_irq_en_ff     <= '0;
         ch_status_ff     <= '0;
         tx_cur_ptr_ff    <= '0;
         rx_cur_ptr_ff    <= '0;
         for (int i = 0; i < 32; i++) begin
            phy_ff[i] <= phy_reset_value(5'(i));
         end
      end else if (update_en) begin
         mac_config_ff    <= mac_config_in;
         mac_irq_en_ff    <= mac_irq_en_in;
         mdio_address_ff  <= mdio_address_in;
         mdio_data_ff     <= mdio_data_in;
         mac_addr_high_ff <= mac_addr_high_in;
         mac_addr_low_ff  <= mac_addr_low_in;
         bus_mode_ff      <= bus_mode_in;
         sysbus_mode_ff   <= sysbus_mode_in;
         ch_control_ff    <= ch_control_in;
         tx_control_ff    <= tx_control_in;
         rx_control_ff    <= rx_control_in;
         tx_base_high_ff  <= tx_base_high_in;
         tx_base_low_ff   <= tx_base_low_in;
         rx_base_high_ff  <= rx_base_high_in;
         rx_base_low_ff   <= rx_base_low_in;
         tx_ring_len_ff   <= tx_ring_len_in;
         rx_ring_len_ff   <= rx_ring_len_in;
         ch_irq_en_ff     <= ch_irq_en_in;
         ch_status_ff     <= ch_status_in;
         tx_cur_ptr_ff    <= tx_cur_ptr_in;
         rx_cur_ptr_ff    <= rx_cur_ptr_in;
         if (phy_we) begin
            phy_ff[phy_waddr] <= phy_wdata;
         end
      end
   end

   // An accepted frame steps the ring pointer by one descriptor or wraps to the base
   a_rx_ptr_step: assert property (@(posedge clock) disable iff (reset)
      update_en && rx_accept |=>
         (rx_cur_ptr_ff == $past(rx_cur_ptr_ff) + RX_DESC_STRIDE) ||
         (rx_cur_ptr_ff == $past(rx_base_low_ff)))
      else $error("rx pointer did not advance or wrap");

   // Write-one-to-clear leaves no written bit set
   a_status_w1c: assert property (@(posedge clock) disable iff (reset)
      update_en && req.opcode == OP_WRITE && req.register_offset == OFF_CH_STATUS |=>
         (ch_status_ff & $past(req.write_data)) == 32'h0)
      else $error("channel status bit survived a write-one-to-clear");

   // BMCR reset and restart bits never stay set in the store
   a_bmcr_clear: assert property (@(posedge clock) disable iff (reset)
      (phy_ff[PHY_REG_BMCR] & PHY_BMCR_RESET_MASK) == 16'h0)
      else $error("BMCR self-clearing bit held in the PHY store");

endmodule

>>> sv/ethernet_mac_register_mdio_block.sv
// Top level: request register, register file and response output register.
//
//   channel   dir   handshake      payload
//   req_ch    in    valid/ready    opcode, register_offset, write_data, rx descriptor/frame
//   rsp_ch    out   valid/ready    read_data, irq_line, rx_outcome, rx writeback fields
//
// An accepted request waits in the request register, then its decode and update
// land in the response register. One request per cycle is sustained while the
// response side is ready; the register file is updated as a request moves into
// the response register.
// Synchronous active-high reset clears control and state, PHY store to its defaults.
// A stalled response holds; the request register fills behind it, then ready drops.
module ethernet_mac_register_mdio_block
   import emrmb_pkg::*;
#(
   parameter int PHY_ADDRESS = PHY_ADDRESS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   emrmb_req_if.sink   req_ch,
   emrmb_rsp_if.source rsp_ch
);

   logic    in_vld_ff, in_vld_in;
   req_type in_req_ff, in_req_in;
   logic    out_vld_ff, out_vld_in;
   rsp_type out_rsp_ff;
   rsp_type rsp_nx;
   logic    advance;
   logic    req_take;

   assign advance      = in_vld_ff && (!out_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !in_vld_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      in_req_in.opcode              = req_ch.opcode;
      in_req_in.register_offset     = req_ch.register_offset;
      in_req_in.write_data          = req_ch.write_data;
      in_req_in.rx_descriptor_owned = req_ch.rx_descriptor_owned;
      in_req_in.rx_frame_size       = req_ch.rx_frame_size;
      in_vld_in  = req_take || (in_vld_ff && !advance);
      out_vld_in = advance || (out_vld_ff && !rsp_ch.ready);
   end

   emrmb_regs #(
      .PHY_ADDRESS(PHY_ADDRESS)
   ) u_regs (
      .clock     (clock),
      .reset     (reset),
      .update_en (advance),
      .req       (in_req_ff),
      .rsp       (rsp_nx)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      if (req_take) begin
         in_req_ff <= in_req_in;
      end
      if (advance) begin
         out_rsp_ff <= rsp_nx;
      end
   end

   assign rsp_ch.valid                = out_vld_ff;
   assign rsp_ch.read_data            = out_rsp_ff.read_data;
   assign rsp_ch.irq_line             = out_rsp_ff.irq_line;
   assign rsp_ch.rx_outcome           = out_rsp_ff.rx_outcome;
   assign rsp_ch.rx_writeback_address = out_rsp_ff.rx_writeback_address;
   assign rsp_ch.rx_writeback_word3   = out_rsp_ff.rx_writeback_word3;

   // A held request is neither lost nor altered while the output is stalled
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !advance |=> in_vld_ff && $stable(in_req_ff))
      else $error("held request lost or changed");

   // Every request that moves on produces a response
   a_advance_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_vld_ff)
      else $error("request advanced without a response");

   // Ready only drops when both stages are occupied and the output is stalled
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> in_vld_ff && out_vld_ff && !rsp_ch.ready)
      else $error("request side stalled without cause");

endmodule

>>> dv/tb_ethernet_mac_register_mdio_block.sv
// Testbench for the MAC/MDIO register block: directed and random requests, scoreboard checks.
`timescale 1ns / 1ps

module tb_ethernet_mac_register_mdio_block
   import emrmb_pkg::*;
();

   // Tracks the register file and PHY store, and holds the responses still owed by the block
   class mac_register_scoreboard;
      bit [31:0] mac_cfg, mac_irq_en, mdio_cmd, mdio_word, mac_addr_hi, mac_addr_lo;
      bit [31:0] bus_mode, sysbus_mode, dma_ch_ctrl, tx_ctrl, rx_ctrl;
      bit [31:0] tx_desc_hi, tx_base_lo, rx_desc_hi, rx_base_lo, tx_ring_len, rx_ring_size;
      bit [31:0] ch_irq_en, dma_ch_stat, tx_cur_ptr, rx_cur_ptr;
      bit [15:0] phy_regs [32];
      bit [4:0]  phy_address;
      rsp_type   awaited_responses [$];
      int        fault_count;

      function new(int phy_addr);
         phy_address = 5'(phy_addr);
         fault_count = 0;
         {mac_cfg, mac_irq_en, mdio_cmd, mdio_word, mac_addr_hi, mac_addr_lo} = '0;
         {bus_mode, sysbus_mode, dma_ch_ctrl, tx_ctrl, rx_ctrl} = '0;
         {tx_desc_hi, tx_base_lo, rx_desc_hi, rx_base_lo, tx_ring_len, rx_ring_size} = '0;
         {ch_irq_en, dma_ch_stat, tx_cur_ptr, rx_cur_ptr} = '0;
         foreach (phy_regs[i]) phy_regs[i] = 16'h0000;
         phy_regs[0] = 16'h1140;
         phy_regs[1] = 16'h796d;
         phy_regs[2] = 16'h0007;
         phy_regs[3] = 16'hc0f0;
         phy_regs[4] = 16'h01e1;
         phy_regs[5] = 16'h45e1;
      endfunction

      function bit [31:0] register_value(offset_type off);
         case (off)
            OFF_VERSION:       return VERSION_VALUE;
            OFF_HW_FEATURE0:   return HW_FEATURE0_VALUE;
            OFF_HW_FEATURE1:   return HW_FEATURE1_VALUE;
            OFF_MAC_CONFIG:    return mac_cfg;
            OFF_MAC_IRQ_EN:    return mac_irq_en;
            OFF_MDIO_ADDRESS:  return mdio_cmd;
            OFF_MDIO_DATA:     return mdio_word;
            OFF_MAC_ADDR_HIGH: return mac_addr_hi;
            OFF_MAC_ADDR_LOW:  return mac_addr_lo;
            OFF_BUS_MODE:      return bus_mode;
            OFF_SYSBUS_MODE:   return sysbus_mode;
            OFF_CH_CONTROL:    return dma_ch_ctrl;
            OFF_TX_CONTROL:    return tx_ctrl;
            OFF_RX_CONTROL:    return rx_ctrl;
            OFF_TX_BASE_HIGH:  return tx_desc_hi;
            OFF_TX_BASE_LOW:   return tx_base_lo;
            OFF_RX_BASE_HIGH:  return rx_desc_hi;
            OFF_RX_BASE_LOW:   return rx_base_lo;
            OFF_TX_RING_LEN:   return tx_ring_len;
            OFF_RX_RING_LEN:   return rx_ring_size;
            OFF_CH_IRQ_EN:     return ch_irq_en;
            OFF_TX_CUR_PTR:    return tx_cur_ptr;
            OFF_RX_CUR_PTR:    return rx_cur_ptr;
            OFF_CH_STATUS:     return dma_ch_stat;
            default:           return 32'h0;
         endcase
      endfunction

      function void phy_write(bit [4:0] idx, bit [15:0] v);
         // IDs are read-only, BMCR self-clearing bits never stick
         if (idx >= PHY_REG_ID_FIRST && idx <= PHY_REG_ID_LAST) return;
         if (idx == PHY_REG_BMCR) v = v & ~PHY_BMCR_RESET_MASK;
         phy_regs[idx] = v;
      endfunction

      function void mdio_access(bit [31:0] v);
         bit [4:0]    phy;
         bit [4:0]    idx;
         mdio_op_type op;
         phy = v[25:21];
         idx = v[20:16];
         op  = v[3:2];
         if (phy == phy_address) begin
            if (op == MDIO_OP_READ) mdio_word = {16'h0000, phy_regs[idx]};
            else if (op == MDIO_OP_WRITE) phy_write(idx, mdio_word[15:0]);
         end else begin
            mdio_word = {16'h0000, MDIO_NO_PHY_DATA};
         end
         mdio_cmd = v & ~32'h1;
      endfunction

      function void register_write(offset_type off, bit [31:0] v);
         case (off)
            OFF_MAC_CONFIG:    mac_cfg = v;
            OFF_MAC_IRQ_EN:    mac_irq_en = v;
            OFF_MAC_ADDR_HIGH: mac_addr_hi = v;
            OFF_MAC_ADDR_LOW:  mac_addr_lo = v;
            OFF_MDIO_DATA:     mdio_word = v;
            OFF_MDIO_ADDRESS: begin
               if (v[0]) mdio_access(v);
               else mdio_cmd = v;
            end
            OFF_BUS_MODE:      bus_mode = v & ~32'h1;
            OFF_SYSBUS_MODE:   sysbus_mode = v;
            OFF_CH_CONTROL:    dma_ch_ctrl = v;
            OFF_TX_CONTROL:    tx_ctrl = v;
            OFF_RX_CONTROL:    rx_ctrl = v;
            OFF_TX_BASE_HIGH:  tx_desc_hi = v;
            OFF_TX_BASE_LOW: begin
               tx_base_lo = v;
               tx_cur_ptr = v;
            end
            OFF_RX_BASE_HIGH:  rx_desc_hi = v;
            OFF_RX_BASE_LOW: begin
               rx_base_lo = v;
               rx_cur_ptr = v;
            end
            OFF_TX_TAIL: begin
               if (tx_ctrl[0]) dma_ch_stat = dma_ch_stat | ST_TI | ST_NIS;
            end
            OFF_TX_RING_LEN:   tx_ring_len = v;
            OFF_RX_RING_LEN:   rx_ring_size = v;
            OFF_CH_IRQ_EN:     ch_irq_en = v;
            OFF_CH_STATUS:     dma_ch_stat = dma_ch_stat & ~v;
            default: ;
         endcase
      endfunction

      // Applies an accepted request and queues the response it must produce
      function void note_request(req_type r);
         rsp_type e;
         e = '0;
         case (r.opcode)
            OP_READ:  e.read_data = register_value(r.register_offset);
            OP_WRITE: register_write(r.register_offset, r.write_data);
            OP_RX_FRAME: begin
               if (!rx_ctrl[0]) begin
                  e.rx_outcome = RX_STOPPED;
               end else if (!r.rx_descriptor_owned) begin
                  e.rx_outcome = RX_DROPPED;
               end else begin
                  e.rx_outcome = RX_ACCEPTED;
                  e.rx_writeback_address = rx_cur_ptr;
                  e.rx_writeback_word3 = RX_WB_FIRST_LAST |
                     (({18'h0, r.rx_frame_size} + 32'd4) & 32'h0000_7fff);
                  rx_cur_ptr = rx_cur_ptr + RX_DESC_STRIDE;
                  // ring end wraps modulo 2^32 like the pointer itself
                  if (rx_cur_ptr > rx_base_lo + rx_ring_size * RX_DESC_STRIDE)
                     rx_cur_ptr = rx_base_lo;
                  dma_ch_stat = dma_ch_stat | ST_RI | ST_NIS;
               end
            end
            default: ;
         endcase
         e.irq_line = |(dma_ch_stat & ch_irq_en & (ST_TI | ST_RI));
         awaited_responses.push_back(e);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
            fault_count++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (awaited_responses.size() == 0) begin
            $display("%0t: response with no request outstanding, expected none, got %h",
                     $time, got);
            fault_count++;
            return;
         end
         e = awaited_responses.pop_front();
         compare_field("read_data", e.read_data, got.read_data);
         compare_field("irq_line", {31'h0, e.irq_line}, {31'h0, got.irq_line});
         compare_field("rx_outcome", {30'h0, e.rx_outcome}, {30'h0, got.rx_outcome});
         compare_field("rx_writeback_address", e.rx_writeback_address,
                       got.rx_writeback_address);
         compare_field("rx_writeback_word3", e.rx_writeback_word3, got.rx_writeback_word3);
      endfunction
   endclass

   localparam int PHY_ADDR        = PHY_ADDRESS_DEFAULT;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int REQUEST_TARGET  = 420;

   // offsets the block does not decode
   localparam offset_type OFF_HW_FEATURE2    = 13'h0124;
   localparam offset_type OFF_HW_FEATURE3    = 13'h0128;
   localparam offset_type OFF_MAC_IRQ_STATUS = 13'h00b0;
   localparam offset_type OFF_RX_TAIL        = 13'h1128;
   localparam offset_type OFF_UNALIGNED      = 13'h0002;
   localparam offset_type OFF_TOP            = 13'h1fff;

   localparam offset_type REG_MAP [0:29] = '{
      OFF_MAC_CONFIG, OFF_VERSION, OFF_MAC_IRQ_EN, OFF_HW_FEATURE0, OFF_HW_FEATURE1,
      OFF_MDIO_ADDRESS, OFF_MDIO_DATA, OFF_MAC_ADDR_HIGH, OFF_MAC_ADDR_LOW, OFF_BUS_MODE,
      OFF_SYSBUS_MODE, OFF_CH_CONTROL, OFF_TX_CONTROL, OFF_RX_CONTROL, OFF_TX_BASE_HIGH,
      OFF_TX_BASE_LOW, OFF_RX_BASE_HIGH, OFF_RX_BASE_LOW, OFF_TX_TAIL, OFF_TX_RING_LEN,
      OFF_RX_RING_LEN, OFF_CH_IRQ_EN, OFF_TX_CUR_PTR, OFF_RX_CUR_PTR, OFF_CH_STATUS,
      OFF_HW_FEATURE2, OFF_HW_FEATURE3, OFF_MAC_IRQ_STATUS, OFF_RX_TAIL, OFF_UNALIGNED
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   emrmb_req_if req_ch ();
   emrmb_rsp_if rsp_ch ();

   ethernet_mac_register_mdio_block #(.PHY_ADDRESS(PHY_ADDR)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   mac_register_scoreboard ledger;
   int sent_count = 0;
   int req_calm   = 0;
   int rsp_calm   = 0;
   int idle_cycles = 0;
   bit rsp_hold_request = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Idle draw: mostly a random gap, now and then a run with no gaps at all
   function automatic int draw_gap(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(10, 30);
         return 0;
      end
      return $urandom_range(0, 11);
   endfunction

   function automatic req_type random_request();
      bit [63:0] noise;
      noise = {$urandom, $urandom};
      return noise[61:0];
   endfunction

   function automatic bit [31:0] mdio_command(bit [4:0] phy, bit [4:0] idx, mdio_op_type op,
                                              bit go);
      bit [31:0] v;
      v = $urandom;
      v[25:21] = phy;
      v[20:16] = idx;
      v[3:2]   = op;
      v[0]     = go;
      return v;
   endfunction

   function automatic bit [31:0] random_mdio_command();
      bit [4:0]    phy;
      mdio_op_type op;
      int          sel;
      phy = ($urandom_range(0, 6) != 0) ? 5'(PHY_ADDR) : 5'($urandom);
      sel = $urandom_range(0, 4);
      op  = (sel < 2) ? MDIO_OP_READ : (sel < 4) ? MDIO_OP_WRITE : mdio_op_type'($urandom);
      return mdio_command(phy, 5'($urandom), op, $urandom_range(0, 9) != 0);
   endfunction

   function automatic bit [31:0] shape_data(offset_type off);
      bit [31:0] v;
      v = $urandom;
      case (off)
         OFF_RX_RING_LEN, OFF_TX_RING_LEN: begin
            if ($urandom_range(0, 3) != 0) v = $urandom_range(0, 6);
         end
         OFF_RX_CONTROL, OFF_TX_CONTROL: begin
            if ($urandom_range(0, 4) != 0) v[0] = 1'b1;
         end
         OFF_RX_BASE_LOW: begin
            // near the top of the address space so the ring end wraps
            if ($urandom_range(0, 2) == 0) v = 32'hffff_ff80 | (v & 32'h0000_0070);
            else v[3:0] = 4'h0;
         end
         OFF_MDIO_ADDRESS: v = random_mdio_command();
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [13:0] random_frame_size();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return 14'h3fff;
      if (sel == 1) return 14'h0000;
      return 14'($urandom);
   endfunction

   task automatic send_request(input req_type r);
      int gap;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid               <= 1'b1;
      req_ch.opcode              <= r.opcode;
      req_ch.register_offset     <= r.register_offset;
      req_ch.write_data          <= r.write_data;
      req_ch.rx_descriptor_owned <= r.rx_descriptor_owned;
      req_ch.rx_frame_size       <= r.rx_frame_size;
      do @(posedge clock); while (!req_ch.ready);
      sent_count++;
   endtask

   task automatic read_reg(input offset_type off);
      req_type r;
      r = random_request();
      r.opcode = OP_READ;
      r.register_offset = off;
      send_request(r);
   endtask

   task automatic write_reg(input offset_type off, input bit [31:0] data);
      req_type r;
      r = random_request();
      r.opcode = OP_WRITE;
      r.register_offset = off;
      r.write_data = data;
      send_request(r);
   endtask

   task automatic rx_frame(input bit owned, input logic [13:0] size);
      req_type r;
      r = random_request();
      r.opcode = OP_RX_FRAME;
      r.rx_descriptor_owned = owned;
      r.rx_frame_size = size;
      send_request(r);
   endtask

   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (ledger.awaited_responses.size() != 0);
   endtask

   // Response side: random back-pressure plus one long hold-off on request
   initial begin : rsp_sink
      int gap;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end
         gap = draw_gap(rsp_calm);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // Request/response monitor and stall watchdog
   always @(posedge clock) begin : monitor
      rsp_type got;
      req_type seen;
      bit      req_fire;
      bit      rsp_fire;
      if (!reset) begin
         req_fire = req_ch.valid && req_ch.ready;
         rsp_fire = rsp_ch.valid && rsp_ch.ready;
         if (rsp_fire) begin
            got = {rsp_ch.read_data, rsp_ch.irq_line, rsp_ch.rx_outcome,
                   rsp_ch.rx_writeback_address, rsp_ch.rx_writeback_word3};
            ledger.check_response(got);
         end
         if (req_fire) begin
            seen = {req_ch.opcode, req_ch.register_offset, req_ch.write_data,
                    req_ch.rx_descriptor_owned, req_ch.rx_frame_size};
            ledger.note_request(seen);
         end
         if (req_fire || rsp_fire) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("%0t: no request or response moved for %0d cycles", $time,
                        idle_cycles);
               $display("tb_ethernet_mac_register_mdio_block NOT OK");
               $finish;
            end
         end
      end
   end

   initial begin : stimulus
      int         pick;
      offset_type off;
      bit         hold_done;
      bit         pause_done;
      req_type    r;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      ledger = new(PHY_ADDR);
      req_ch.valid               <= 1'b0;
      req_ch.opcode              <= OP_NONE;
      req_ch.register_offset     <= '0;
      req_ch.write_data          <= '0;
      req_ch.rx_descriptor_owned <= 1'b0;
      req_ch.rx_frame_size       <= '0;
      reset <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // fixed IDs, undecoded and unaligned offsets
      read_reg(OFF_VERSION);
      read_reg(OFF_HW_FEATURE1);
      read_reg(OFF_HW_FEATURE2);
      read_reg(OFF_UNALIGNED);
      read_reg(OFF_TOP);
      write_reg(OFF_MAC_CONFIG, 32'hffff_ffff);
      read_reg(OFF_MAC_CONFIG);
      // soft reset bit never reads back
      write_reg(OFF_BUS_MODE, 32'hffff_ffff);
      read_reg(OFF_BUS_MODE);
      write_reg(OFF_VERSION, 32'h0);
      r = random_request();
      r.opcode = OP_NONE;
      send_request(r);
      // PHY: BMCR read, masked write, write to an ID register, absent PHY
      write_reg(OFF_MDIO_DATA, 32'hffff_ffff);
      write_reg(OFF_MDIO_ADDRESS, mdio_command(5'(PHY_ADDR), PHY_REG_BMCR, MDIO_OP_WRITE, 1'b1));
      write_reg(OFF_MDIO_ADDRESS,
                mdio_command(5'(PHY_ADDR), PHY_REG_ID_FIRST, MDIO_OP_WRITE, 1'b1));
      write_reg(OFF_MDIO_ADDRESS, mdio_command(5'(PHY_ADDR), PHY_REG_BMCR, MDIO_OP_READ, 1'b1));
      read_reg(OFF_MDIO_DATA);
      write_reg(OFF_MDIO_ADDRESS,
                mdio_command(5'(PHY_ADDR + 1), PHY_REG_BMCR, MDIO_OP_READ, 1'b1));
      write_reg(OFF_MDIO_ADDRESS, 32'hffff_fffe);
      // receive stopped, then dropped, accepted and wrapping at the top of memory
      rx_frame(1'b1, 14'h3fff);
      write_reg(OFF_CH_IRQ_EN, 32'hffff_ffff);
      write_reg(OFF_RX_CONTROL, 32'h1);
      write_reg(OFF_RX_BASE_LOW, 32'hffff_fff0);
      rx_frame(1'b0, 14'h3fff);
      rx_frame(1'b1, 14'h3fff);
      rx_frame(1'b1, 14'h0000);
      write_reg(OFF_TX_CONTROL, 32'h1);
      write_reg(OFF_TX_TAIL, 32'h0);
      write_reg(OFF_CH_STATUS, 32'hffff_ffff);
      drain_responses();

      while (sent_count < REQUEST_TARGET) begin
         if (!hold_done && sent_count >= 150) begin
            hold_done = 1'b1;
            rsp_hold_request = 1'b1;
         end
         if (!pause_done && sent_count >= 320) begin
            pause_done = 1'b1;
            drain_responses();
         end
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            read_reg(REG_MAP[$urandom_range(0, 29)]);
         end else if (pick < 25) begin
            read_reg(offset_type'($urandom));
         end else if (pick < 45) begin
            off = REG_MAP[$urandom_range(0, 29)];
            write_reg(off, shape_data(off));
         end else if (pick < 48) begin
            write_reg(offset_type'($urandom), $urandom);
         end else if (pick < 63) begin
            write_reg(OFF_MDIO_DATA, $urandom);
            write_reg(OFF_MDIO_ADDRESS, random_mdio_command());
            read_reg(OFF_MDIO_DATA);
         end else if (pick < 90) begin
            rx_frame($urandom_range(0, 4) != 0, random_frame_size());
         end else if (pick < 95) begin
            write_reg(($urandom_range(0, 1) != 0) ? OFF_TX_TAIL : OFF_CH_STATUS, $urandom);
         end else begin
            r = random_request();
            if ($urandom_range(0, 1) != 0) r.opcode = OP_NONE;
            send_request(r);
         end
      end

      drain_responses();
      repeat (4) @(posedge clock);
      if (ledger.fault_count == 0 && ledger.awaited_responses.size() == 0)
         $display("tb_ethernet_mac_register_mdio_block OK");
      else
         $display("tb_ethernet_mac_register_mdio_block NOT OK");
      $finish;
   end
endmodule
